### sv/rtc_calendar_stopwatch_timer_defines.svh
// Assertion macros shared by the checker of the clock block.
`ifndef RTC_CALENDAR_STOPWATCH_TIMER_DEFINES_SVH
`define RTC_CALENDAR_STOPWATCH_TIMER_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define RCST_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("clock block check failed");

// Next-cycle implication, off while in reset.
`define RCST_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("clock block check failed");

// Next-cycle implication that also covers the reset cycles.
`define RCST_ASSERT_RESET(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("clock block check failed");

`endif

### sv/rcst_pkg.sv
// Types, codes and constants shared by the clock, calendar and timer modules.
package rcst_pkg;

  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 88;

  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SW_TOGGLE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SW_CLEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TM_TOGGLE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TM_CLEAR  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_ALARM_HOUR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_MINUTE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOUR_MODE    = 2'd2;

  localparam logic [15:0] YEAR_WRAP_AT = 16'd32999;
  localparam logic [15:0] YEAR_RESTART = 16'd2000;

  // Reciprocal of 100 scaled by 2**23, rounded up; exact quotient for 16-bit years.
  localparam logic [16:0] DIV100_MUL = 17'd83887;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [2:0]  weekday;
    logic [15:0] year;
  } tod_t;

  // Packs as hour*4096 + minute*64 + second.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  typedef struct packed {
    tod_t tod;
    logic sw_running;
    hms_t sw;
    logic tm_running;
    hms_t tm;
  } state_t;

  typedef struct packed {
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic       hour_mode;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    tod_t             load;
  } req_t;

endpackage

### sv/rcst_calendar.sv
// One-second step of the time of day with weekday, month length and leap-year rollover.
module rcst_calendar import rcst_pkg::*; (
  input  tod_t cur,
  output tod_t nxt
);

  logic [24:0] year_prod;
  logic        div100;
  logic        leap;
  logic [4:0]  month_len;
  logic [4:0]  day_step;
  logic [3:0]  month_step;
  logic        midnight;

  // frac below the multiplier means the remainder by 100 is zero
  assign year_prod = 25'(33'(cur.year) * 33'(DIV100_MUL));
  assign div100    = (year_prod[22:0] < 23'(DIV100_MUL));
  assign leap      = (cur.year[1:0] == 2'd0) && (!div100 || (year_prod[24:23] == 2'd0));

  always_comb begin
    case (cur.month) inside
      4'd2:                    month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default:                 month_len = 5'd31;
    endcase
  end

  assign day_step   = (cur.day >= month_len) ? 5'd1 : cur.day + 5'd1;
  assign month_step = (cur.month >= 4'd12) ? 4'd1 : cur.month + 4'd1;
  assign midnight   = (cur.second >= 6'd59) && (cur.minute >= 6'd59) && (cur.hour >= 5'd23);

  always_comb begin
    nxt = cur;
    if (cur.second >= 6'd59) begin
      nxt.second = 6'd0;
      if (cur.minute >= 6'd59) begin
        nxt.minute = 6'd0;
        nxt.hour   = (cur.hour >= 5'd23) ? 5'd0 : cur.hour + 5'd1;
      end else begin
        nxt.minute = cur.minute + 6'd1;
      end
    end else begin
      nxt.second = cur.second + 6'd1;
    end
    if (midnight) begin
      nxt.weekday = (cur.weekday >= 3'd7) ? 3'd1 : cur.weekday + 3'd1;
      nxt.day     = day_step;
      if (day_step == 5'd1) begin
        nxt.month = month_step;
        if (month_step == 4'd1) begin
          nxt.year = (cur.year >= YEAR_WRAP_AT) ? YEAR_RESTART : cur.year + 16'd1;
        end
      end
    end
  end

endmodule

### sv/rcst_core.sv
// Clock, stopwatch and timer state with command decode and configuration registers.
module rcst_core import rcst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  req_t                  req,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output state_t                state_next,
  output cfg_t                  cfg
);

  state_t state;
  tod_t   tod_ticked;

  function automatic hms_t hms_up(input hms_t v);
    hms_t r;
    r = v;
    if (v.second >= 6'd59) begin
      r.second = 6'd0;
      if (v.minute >= 6'd59) begin
        r.minute = 6'd0;
        r.hour   = (v.hour >= 5'd23) ? 5'd0 : v.hour + 5'd1;
      end else begin
        r.minute = v.minute + 6'd1;
      end
    end else begin
      r.second = v.second + 6'd1;
    end
    return r;
  endfunction

  function automatic hms_t hms_down(input hms_t v);
    hms_t r;
    r = v;
    if (v.second == 6'd0) begin
      r.second = 6'd59;
      if (v.minute == 6'd0) begin
        r.minute = 6'd59;
        r.hour   = (v.hour == 5'd0) ? 5'd23 : v.hour - 5'd1;
      end else begin
        r.minute = v.minute - 6'd1;
      end
    end else begin
      r.second = v.second - 6'd1;
    end
    return r;
  endfunction

  rcst_calendar u_calendar (
    .cur (state.tod),
    .nxt (tod_ticked)
  );

  always_comb begin
    state_next = state;
    unique case (req.cmd)
      CMD_TICK: begin
        if (state.sw_running) state_next.sw = hms_up(state.sw);
        if (state.tm_running) state_next.tm = hms_down(state.tm);
        state_next.tod = tod_ticked;
      end
      CMD_LOAD:      state_next.tod        = req.load;
      CMD_SW_TOGGLE: state_next.sw_running = !state.sw_running;
      CMD_SW_CLEAR:  state_next.sw         = '0;
      CMD_TM_TOGGLE: state_next.tm_running = !state.tm_running;
      CMD_TM_CLEAR:  state_next.tm         = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.tod.hour    <= 5'd16;
      state.tod.minute  <= 6'd0;
      state.tod.second  <= 6'd50;
      state.tod.day     <= 5'd9;
      state.tod.month   <= 4'd8;
      state.tod.weekday <= 3'd3;
      state.tod.year    <= 16'd2022;
      state.sw_running  <= 1'b0;
      state.sw          <= '0;
      state.tm_running  <= 1'b0;
      state.tm          <= '{hour: 5'd6, minute: 6'd6, second: 6'd6};
    end else if (step) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_hour   <= 5'd16;
      cfg.alarm_minute <= 6'd15;
      cfg.hour_mode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALARM_HOUR:   cfg.alarm_hour   <= cfg_data[4:0];
        REG_ALARM_MINUTE: cfg.alarm_minute <= cfg_data;
        REG_HOUR_MODE:    cfg.hour_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### sv/rcst_view.sv
// Result formatting: twelve-hour view, alarm compare and packing of the result word.
module rcst_view import rcst_pkg::*; (
  input  state_t               st,
  input  cfg_t                 cfg,
  output logic [M_TDATA_W-1:0] result
);

  logic [4:0] hour_mod12;
  logic [4:0] shown_hour;
  logic       is_pm;
  logic       alarm_match;

  always_comb begin
    if (st.tod.hour >= 5'd24)      hour_mod12 = st.tod.hour - 5'd24;
    else if (st.tod.hour >= 5'd12) hour_mod12 = st.tod.hour - 5'd12;
    else                           hour_mod12 = st.tod.hour;
  end

  always_comb begin
    if (cfg.hour_mode)                                       shown_hour = st.tod.hour;
    else if (st.tod.hour == 5'd0 || st.tod.hour == 5'd12)    shown_hour = 5'd12;
    else                                                     shown_hour = hour_mod12;
  end

  assign is_pm       = !cfg.hour_mode && (st.tod.hour > 5'd11);
  assign alarm_match = (st.tod.hour == cfg.alarm_hour) && (st.tod.minute == cfg.alarm_minute);

  assign result = {7'd0, st.tm, st.sw, alarm_match, st.tod.year, st.tod.weekday,
                   st.tod.month, st.tod.day, st.tod.second, st.tod.minute, is_pm, shown_hour};

endmodule

### sv/rtc_calendar_stopwatch_timer.sv
// Real-time clock with calendar, stopwatch and countdown timer on stream channels.
//
//  channel   | direction | signals                               | carries
//  ----------+-----------+---------------------------------------+---------------------------
//  s_*       | in        | s_tvalid s_tready s_tdata s_tuser     | command and load values
//  m_*       | out       | m_tvalid m_tready m_tdata             | time, date, alarm, counters
//  cfg_*     | in        | cfg_we cfg_index cfg_data             | alarm hour/minute, hour mode
//
// One request per cycle while no result is held; each request gives one result by way of
// the request register and the result register, with the calendar step and result
// formatting between them; the leap-year test (one 16x17 multiply) sets the path length.
// Reset is synchronous: time 16:00:50, 9 Aug 2022, weekday 3, timer 6:06:06.
// A held result stalls the request register; a new request is still taken while
// the result register drains.
module rtc_calendar_stopwatch_timer import rcst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // hour[4:0] minute[10:5] second[16:11] day[21:17] month[25:22] weekday[28:26]
  // year[44:29], zero pad [47:45]
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // command[2:0]
  input  logic [CMD_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // shown_hour[4:0] is_pm[5] minute[11:6] second[17:12] day[22:18] month[26:23]
  // weekday[29:27] year[45:30] alarm_match[46] stopwatch[63:47] timer[80:64], pad [87:81]
  output logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                 in_valid;
  req_t                 in_req;
  logic                 advance;
  logic                 step;
  state_t               state_next;
  cfg_t                 cfg;
  logic [M_TDATA_W-1:0] result;

  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req.cmd          <= s_tuser;
      in_req.load.hour    <= s_tdata[4:0];
      in_req.load.minute  <= s_tdata[10:5];
      in_req.load.second  <= s_tdata[16:11];
      in_req.load.day     <= s_tdata[21:17];
      in_req.load.month   <= s_tdata[25:22];
      in_req.load.weekday <= s_tdata[28:26];
      in_req.load.year    <= s_tdata[44:29];
    end
  end

  rcst_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .req        (in_req),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .state_next (state_next),
    .cfg        (cfg)
  );

  rcst_view u_view (
    .st     (state_next),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= result;
    end
  end

endmodule

### sv/rcst_checker.sv
// Port-level checks on the clock block, bound to its top level.
`include "rtc_calendar_stopwatch_timer_defines.svh"

module rcst_checker import rcst_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  `RCST_ASSERT_RESET(a_reset_empty, rst, !m_tvalid)
  `RCST_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `RCST_ASSERT_NEXT(a_request_gives_result, s_tvalid && s_tready, ##1 m_tvalid)
  `RCST_ASSERT_IMPL(a_pm_hour_range, m_tvalid && m_tdata[5], m_tdata[4:0] <= 5'd12)

endmodule

bind rtc_calendar_stopwatch_timer rcst_checker u_checker (.*);

### dv/testbench.sv
// Self-checking testbench for the real-time clock, calendar, stopwatch and countdown timer.
module testbench;
  import rcst_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 192;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [2:0]  pad;
    logic [15:0] year;
    logic [2:0]  weekday;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
  } load_word_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [16:0] timer;
    logic [16:0] stopwatch;
    logic        alarm;
    logic [15:0] year;
    logic [2:0]  weekday;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic        is_pm;
    logic [4:0]  shown_hour;
  } clock_view_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    load_word_t       ld;
    bit               fixed;
    clock_view_t      view;
  } stimulus_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic [CMD_W-1:0]      s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tod_t  tod_now;
  hms_t  sw_now;
  hms_t  tm_now;
  logic  sw_run;
  logic  tm_run;
  cfg_t  cfg_now;

  clock_view_t   pending_views[$];
  stimulus_row_t directed_rows[$];
  int unsigned   mismatch_count;
  int unsigned   cycle_count;

  rtc_calendar_stopwatch_timer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic hms_t count_up(input hms_t v);
    hms_t r;
    r = v;
    if (v.second >= 6'd59) begin
      r.second = '0;
      if (v.minute >= 6'd59) begin
        r.minute = '0;
        r.hour   = (v.hour >= 5'd23) ? 5'd0 : v.hour + 5'd1;
      end else begin
        r.minute = v.minute + 6'd1;
      end
    end else begin
      r.second = v.second + 6'd1;
    end
    return r;
  endfunction

  function automatic hms_t count_down(input hms_t v);
    hms_t r;
    r = v;
    if (v.second == 6'd0) begin
      r.second = 6'd59;
      if (v.minute == 6'd0) begin
        r.minute = 6'd59;
        r.hour   = (v.hour == 5'd0) ? 5'd23 : v.hour - 5'd1;
      end else begin
        r.minute = v.minute - 6'd1;
      end
    end else begin
      r.second = v.second - 6'd1;
    end
    return r;
  endfunction

  function automatic int unsigned days_in_month(input logic [3:0] month, input logic [15:0] year);
    int unsigned y;
    bit          leap;
    y    = {16'd0, year};
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    if (month == 4'd2) return leap ? 29 : 28;
    if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) return 30;
    return 31;
  endfunction

  task automatic step_day();
    tod_now.weekday = (tod_now.weekday >= 3'd7) ? 3'd1 : tod_now.weekday + 3'd1;
    if (tod_now.day >= days_in_month(tod_now.month, tod_now.year))
      tod_now.day = 5'd1;
    else
      tod_now.day = tod_now.day + 5'd1;
    if (tod_now.day == 5'd1) begin
      tod_now.month = (tod_now.month >= 4'd12) ? 4'd1 : tod_now.month + 4'd1;
      if (tod_now.month == 4'd1)
        tod_now.year = (tod_now.year >= 16'd32999) ? 16'd2000 : tod_now.year + 16'd1;
    end
  endtask

  task automatic advance_second();
    if (sw_run) sw_now = count_up(sw_now);
    if (tm_run) tm_now = count_down(tm_now);
    if (tod_now.second >= 6'd59) begin
      tod_now.second = '0;
      if (tod_now.minute >= 6'd59) begin
        tod_now.minute = '0;
        if (tod_now.hour >= 5'd23) begin
          tod_now.hour = '0;
          step_day();
        end else begin
          tod_now.hour = tod_now.hour + 5'd1;
        end
      end else begin
        tod_now.minute = tod_now.minute + 6'd1;
      end
    end else begin
      tod_now.second = tod_now.second + 6'd1;
    end
  endtask

  task automatic predict_view(input logic [CMD_W-1:0] cmd, input load_word_t ld,
                              output clock_view_t v);
    case (cmd)
      CMD_TICK: advance_second();
      CMD_LOAD: begin
        tod_now.hour    = ld.hour;
        tod_now.minute  = ld.minute;
        tod_now.second  = ld.second;
        tod_now.day     = ld.day;
        tod_now.month   = ld.month;
        tod_now.weekday = ld.weekday;
        tod_now.year    = ld.year;
      end
      CMD_SW_TOGGLE: sw_run = ~sw_run;
      CMD_SW_CLEAR:  sw_now = '0;
      CMD_TM_TOGGLE: tm_run = ~tm_run;
      CMD_TM_CLEAR:  tm_now = '0;
      default: ;
    endcase
    v = '0;
    if (cfg_now.hour_mode)
      v.shown_hour = tod_now.hour;
    else if (tod_now.hour == 5'd0 || tod_now.hour == 5'd12)
      v.shown_hour = 5'd12;
    else
      v.shown_hour = tod_now.hour % 5'd12;
    v.is_pm     = !cfg_now.hour_mode && tod_now.hour > 5'd11;
    v.minute    = tod_now.minute;
    v.second    = tod_now.second;
    v.day       = tod_now.day;
    v.month     = tod_now.month;
    v.weekday   = tod_now.weekday;
    v.year      = tod_now.year;
    v.alarm     = tod_now.hour == cfg_now.alarm_hour && tod_now.minute == cfg_now.alarm_minute;
    v.stopwatch = sw_now;
    v.timer     = tm_now;
  endtask

  function automatic load_word_t make_load(input int h, m, s, d, mo, wd, y);
    load_word_t ld;
    ld         = '0;
    ld.hour    = 5'(h);
    ld.minute  = 6'(m);
    ld.second  = 6'(s);
    ld.day     = 5'(d);
    ld.month   = 4'(mo);
    ld.weekday = 3'(wd);
    ld.year    = 16'(y);
    return ld;
  endfunction

  function automatic clock_view_t make_view(input int sh, pm, m, s, d, mo, wd, y, al, sw, tm);
    clock_view_t v;
    v            = '0;
    v.shown_hour = 5'(sh);
    v.is_pm      = 1'(pm);
    v.minute     = 6'(m);
    v.second     = 6'(s);
    v.day        = 5'(d);
    v.month      = 4'(mo);
    v.weekday    = 3'(wd);
    v.year       = 16'(y);
    v.alarm      = 1'(al);
    v.stopwatch  = 17'(sw);
    v.timer      = 17'(tm);
    return v;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] cmd, input load_word_t ld,
                         input bit fixed, input clock_view_t view);
    stimulus_row_t row;
    row.cmd   = cmd;
    row.ld    = ld;
    row.fixed = fixed;
    row.view  = view;
    directed_rows.push_back(row);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic compare_view(input clock_view_t want, input clock_view_t got);
    check_field("shown_hour", want.shown_hour, got.shown_hour);
    check_field("is_pm", want.is_pm, got.is_pm);
    check_field("minute", want.minute, got.minute);
    check_field("second", want.second, got.second);
    check_field("day", want.day, got.day);
    check_field("month", want.month, got.month);
    check_field("weekday", want.weekday, got.weekday);
    check_field("year", want.year, got.year);
    check_field("alarm_match", want.alarm, got.alarm);
    check_field("stopwatch", want.stopwatch, got.stopwatch);
    check_field("timer", want.timer, got.timer);
    check_field("pad", want.pad, got.pad);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_views.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result with no request pending: %h", m_tdata);
      end else begin
        compare_view(pending_views.pop_front(), clock_view_t'(m_tdata));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned stall_mode;
    int unsigned span;
    int unsigned period;
    int unsigned low_len;
    m_tready = 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 2);
      span       = $urandom_range(20, 200);
      period     = $urandom_range(2, 8);
      low_len    = $urandom_range(1, period - 1);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (stall_mode)
          0:       m_tready = 1'b1;
          1:       m_tready = 1'($urandom_range(0, 1));
          default: m_tready = (k % period) >= low_len;
        endcase
      end
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input load_word_t ld,
                              input bit fixed, input clock_view_t fixed_view);
    clock_view_t v;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = ld;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_view(cmd, ld, v);
    pending_views.push_back(fixed ? fixed_view : v);
  endtask

  task automatic hold_off(input int unsigned n);
    if (n != 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ALARM_HOUR:   cfg_now.alarm_hour   = 5'(value);
      REG_ALARM_MINUTE: cfg_now.alarm_minute = 6'(value);
      REG_HOUR_MODE:    cfg_now.hour_mode    = 1'(value);
      default: ;
    endcase
  endtask

  task automatic random_request(output logic [CMD_W-1:0] cmd, output load_word_t ld);
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    ld   = make_load($urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 7),
                     $urandom_range(0, 65535));
    cmd  = CMD_TICK;
    if (pick < 14) begin
      cmd      = CMD_LOAD;
      ld.month = ($urandom_range(0, 2) == 0) ? 4'd2 : 4'($urandom_range(1, 12));
      case ($urandom_range(0, 4))
        0:       ld.year = 16'($urandom_range(2000, 2120));
        1:       ld.year = 16'($urandom_range(0, 329) * 100);
        2:       ld.year = 16'($urandom_range(5, 82) * 400);
        3:       ld.year = 16'($urandom_range(32990, 32999));
        default: ld.year = 16'($urandom_range(0, 32999));
      endcase
      len = days_in_month(ld.month, ld.year);
      ld.day = 5'(len - 1 + $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) ld.day = 5'($urandom_range(1, len));
      ld.weekday = 3'($urandom_range(1, 7));
      case ($urandom_range(0, 3)) inside
        0, 1:    ld.hour = 5'd23;
        2:       ld.hour = cfg_now.alarm_hour;
        default: ld.hour = 5'($urandom_range(0, 23));
      endcase
      case ($urandom_range(0, 3)) inside
        0, 1:    ld.minute = 6'd59;
        2:       ld.minute = cfg_now.alarm_minute;
        default: ld.minute = 6'($urandom_range(0, 59));
      endcase
      ld.second = 6'($urandom_range(50, 59));
    end else if (pick < 20) begin
      cmd = CMD_LOAD;
    end else if (pick < 24) begin
      cmd = CMD_SW_TOGGLE;
    end else if (pick < 27) begin
      cmd = CMD_SW_CLEAR;
    end else if (pick < 31) begin
      cmd = CMD_TM_TOGGLE;
    end else if (pick < 34) begin
      cmd = CMD_TM_CLEAR;
    end else if (pick < 37) begin
      cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
    end
    ld.pad = '0;
  endtask

  initial begin
    logic [CMD_W-1:0] cmd;
    load_word_t       ld;
    int unsigned      burst_left;
    int unsigned      gap;
    mismatch_count = 0;
    cycle_count    = 0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = CMD_TICK;
    cfg_we         = 1'b0;
    cfg_index      = REG_ALARM_HOUR;
    cfg_data       = '0;

    tod_now      = '{hour: 5'd16, minute: 6'd0, second: 6'd50, day: 5'd9, month: 4'd8,
                     weekday: 3'd3, year: 16'd2022};
    sw_now       = '0;
    tm_now       = '{hour: 5'd6, minute: 6'd6, second: 6'd6};
    sw_run       = 1'b0;
    tm_run       = 1'b0;
    cfg_now      = '{alarm_hour: 5'd16, alarm_minute: 6'd15, hour_mode: 1'b0};

    add_row(CMD_SPARE_7, '0, 1, make_view(4, 1, 0, 50, 9, 8, 3, 2022, 0, 0, 24966));
    add_row(CMD_SPARE_6, '0, 1, make_view(4, 1, 0, 50, 9, 8, 3, 2022, 0, 0, 24966));
    add_row(CMD_LOAD, make_load(23, 59, 59, 31, 12, 7, 32999), 1,
            make_view(11, 1, 59, 59, 31, 12, 7, 32999, 0, 0, 24966));
    add_row(CMD_TICK, '0, 1, make_view(12, 0, 0, 0, 1, 1, 1, 2000, 0, 0, 24966));
    add_row(CMD_SW_TOGGLE, '0, 0, '0);
    add_row(CMD_TM_TOGGLE, '0, 0, '0);
    add_row(CMD_TICK, '0, 0, '0);
    add_row(CMD_TM_CLEAR, '0, 0, '0);
    add_row(CMD_TICK, '0, 0, '0);
    add_row(CMD_SW_CLEAR, '0, 0, '0);
    add_row(CMD_LOAD, make_load(23, 59, 59, 28, 2, 3, 2024), 0, '0);
    add_row(CMD_TICK, '0, 0, '0);
    add_row(CMD_LOAD, make_load(23, 59, 59, 28, 2, 1, 1900), 0, '0);
    add_row(CMD_TICK, '0, 0, '0);
    add_row(CMD_LOAD, make_load(23, 59, 59, 29, 2, 2, 2000), 0, '0);
    add_row(CMD_TICK, '0, 0, '0);
    add_row(CMD_LOAD, make_load(31, 63, 63, 31, 15, 0, 65535), 0, '0);
    add_row(CMD_TICK, '0, 0, '0);
    add_row(CMD_LOAD, make_load(0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(CMD_TICK, '0, 0, '0);
    add_row(CMD_LOAD, make_load(23, 59, 59, 0, 0, 0, 0), 0, '0);
    add_row(CMD_TICK, '0, 0, '0);
    add_row(CMD_LOAD, make_load(16, 15, 0, 9, 8, 3, 2022), 0, '0);
    add_row(CMD_SW_TOGGLE, '0, 0, '0);
    add_row(CMD_TM_TOGGLE, '0, 0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].ld, directed_rows[i].fixed,
                   directed_rows[i].view);
      hold_off($urandom_range(0, 2));
    end

    burst_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin
          write_register(REG_ALARM_HOUR, 0);
          write_register(REG_ALARM_MINUTE, 0);
          write_register(REG_HOUR_MODE, 0);
        end
        1: begin
          write_register(REG_ALARM_HOUR, 23);
          write_register(REG_ALARM_MINUTE, 59);
          write_register(REG_HOUR_MODE, 1);
        end
        2: begin
          write_register(REG_ALARM_HOUR, 31);
          write_register(REG_ALARM_MINUTE, 63);
          write_register(REG_HOUR_MODE, 0);
        end
        default: begin
          write_register(REG_ALARM_HOUR, $urandom_range(0, 23));
          write_register(REG_ALARM_MINUTE, $urandom_range(0, 59));
          write_register(REG_HOUR_MODE, $urandom_range(0, 1));
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
          hold_off(gap);
          burst_left = $urandom_range(1, 40);
        end
        if ($urandom_range(0, 199) == 0) drain();
        random_request(cmd, ld);
        send_request(cmd, ld, 0, '0);
        burst_left--;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### rtc_calendar_stopwatch_timer.f
+incdir+sv
sv/rcst_pkg.sv
sv/rcst_calendar.sv
sv/rcst_core.sv
sv/rcst_view.sv
sv/rtc_calendar_stopwatch_timer.sv
sv/rcst_checker.sv
dv/testbench.sv
